// ===== design/toce_pkg.sv =====
// ----------------------------------------------------------------------------
// toce_pkg: shared types and codes for the two-operand register execute block
// Holds opcodes, payload structs and the divider control struct.
// ----------------------------------------------------------------------------
package toce_pkg;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_SUB   = 5'd1,
    OP_MUL   = 5'd2,
    OP_DIV   = 5'd3,
    OP_STORE = 5'd4,
    OP_LOAD  = 5'd5,
    OP_IMM   = 5'd6,
    OP_EQ    = 5'd7,
    OP_LT    = 5'd8,
    OP_LE    = 5'd9,
    OP_GT    = 5'd10,
    OP_GE    = 5'd11,
    OP_JMP   = 5'd12,
    OP_JMPC  = 5'd13,
    OP_CALL  = 5'd14,
    OP_RET   = 5'd15,
    OP_PRINT = 5'd16
  } op_e;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_FULL  = 2'd1;
  localparam logic [1:0] FAULT_EMPTY = 2'd2;

  typedef struct packed {
    logic [4:0]         opcode;
    logic [9:0]         field_a;
    logic signed [15:0] field_b;
  } in_word_t;

  typedef struct packed {
    logic [9:0]         next_pc;
    logic               print_valid;
    logic signed [31:0] print_reg_value;
    logic signed [31:0] print_mem_value;
    logic [1:0]         stack_fault;
  } out_word_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// ===== design/toce_div.sv =====
// ----------------------------------------------------------------------------
// toce_div: iterative signed divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// A zero divisor returns zero.
// ----------------------------------------------------------------------------
module toce_div #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DATA_WIDTH-1:0] dividend_i,
  input  logic [DATA_WIDTH-1:0] divisor_i,
  output toce_pkg::div_ctl_t    ctl_o,
  output logic [DATA_WIDTH-1:0] quot_o
);
  import toce_pkg::*;

  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] rem_q, quo_q, den_q;
  logic                  neg_q, zero_q, busy_q, done_q;
  logic [CW-1:0]         cnt_q;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH-1:0] mx, my;

  assign mx    = dividend_i[DATA_WIDTH-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign my    = divisor_i[DATA_WIDTH-1] ? (~divisor_i + 1'b1) : divisor_i;
  assign trial = {rem_q, quo_q[DATA_WIDTH-1]} - {1'b0, den_q};

  // one shift-subtract step per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DATA_WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= mx;
      den_q  <= my;
      neg_q  <= dividend_i[DATA_WIDTH-1] ^ divisor_i[DATA_WIDTH-1];
      zero_q <= (divisor_i == '0);
    end else if (busy_q) begin
      if (!trial[DATA_WIDTH]) begin
        rem_q <= trial[DATA_WIDTH-1:0];
        quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DATA_WIDTH-2:0], quo_q[DATA_WIDTH-1]};
        quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quot_o      = zero_q ? '0 : (neg_q ? (~quo_q + 1'b1) : quo_q);
  assign ctl_o.start = start_i;
  assign ctl_o.busy  = busy_q;
  assign ctl_o.done  = done_q;
endmodule

// ===== design/two_operand_register_cpu_execute.sv =====
// ----------------------------------------------------------------------------
// two_operand_register_cpu_execute: instruction execute block
// Runs one instruction per input word against the register file, data memory
// and return stack.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i/in_stall_o, in_data_i): one instruction word.
//   out channel (out_valid_o/out_stall_i, out_data_o): one result word each.
//   An instruction is accepted when in_valid_i is high and in_stall_o low.
//   Sequencer: accept -> read (register file) -> exec (memory read) ->
//   write back -> result. A div waits between exec and write back in the
//   iterative divider until it signals done.
//   The block accepts the next word once it is idle and the result register
//   is free, so a new word never starts before the last result is taken.
//   After reset a clearing pass writes zero to every data memory word, one
//   word per cycle, before the first word is accepted; the register file
//   clears at once. When out_stall_i is high the result holds in the output
//   register and no new instruction starts until the result is taken.
// ----------------------------------------------------------------------------
module two_operand_register_cpu_execute #(
  parameter int NUM_REGS    = 16,
  parameter int MEM_WORDS   = 1024,
  parameter int STACK_DEPTH = 8,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  toce_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output toce_pkg::out_word_t  out_data_o
);
  import toce_pkg::*;

  localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int MW = $clog2(MEM_WORDS);
  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_EXEC  = 6'b001000,
    S_DIV   = 6'b010000,
    S_WB    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [DATA_WIDTH-1:0] regs_q [NUM_REGS];
  logic [DATA_WIDTH-1:0] mem [MEM_WORDS];
  logic [9:0]            stk [STACK_DEPTH];
  logic [DW-1:0]         depth_q;
  logic [9:0]            pc_q;
  logic [MW-1:0]         clr_q;

  in_word_t              ins_q;
  logic [DATA_WIDTH-1:0] ra_q, rb_q, mrd_q, res_q;
  logic [9:0]            srd_q;
  logic                  ovalid_q;
  out_word_t             out_q;

  logic [RW-1:0]         ia, ib;
  logic [MW-1:0]         maddr;
  logic                  div_start;
  div_ctl_t              dctl;
  logic [DATA_WIDTH-1:0] quot;
  logic                  lt_ab, lt_ba;
  logic [DATA_WIDTH-1:0] ones;
  logic [DATA_WIDTH-1:0] bimm;

  assign ia    = RW'(ins_q.field_a);
  assign ib    = RW'(ins_q.field_b);
  assign ones  = '1;
  assign bimm  = DATA_WIDTH'(signed'(ins_q.field_b));
  assign lt_ab = $signed(ra_q) < $signed(rb_q);
  assign lt_ba = $signed(rb_q) < $signed(ra_q);

  // data memory address for the exec-cycle read
  always_comb begin
    case (op_e'(ins_q.opcode))
      OP_LOAD:  maddr = MW'(rb_q);
      OP_CALL:  maddr = MW'(ins_q.field_a);
      default:  maddr = MW'(ins_q.field_b);
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE) || ovalid_q;
  assign div_start  = (state_q == S_EXEC) && (ins_q.opcode == OP_DIV);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == MW'(MEM_WORDS - 1)) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i && !in_stall_o) state_d = S_READ;
      S_READ:  state_d = S_EXEC;
      S_EXEC:  state_d = (ins_q.opcode == OP_DIV) ? S_DIV : S_WB;
      S_DIV:   if (dctl.done) state_d = S_WB;
      S_WB:    state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
    end
  end

  // operand capture
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i && !in_stall_o) ins_q <= in_data_i;
    if (state_q == S_READ) begin
      ra_q  <= regs_q[ia];
      rb_q  <= regs_q[ib];
      srd_q <= stk[SW'(depth_q - 1'b1)];
    end
  end

  // data memory: one read port, one write port
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) mem[clr_q] <= '0;
    else if (state_q == S_WB && ins_q.opcode == OP_STORE) mem[MW'(ra_q)] <= rb_q;
    if (state_q == S_EXEC) mrd_q <= mem[maddr];
  end

  // ALU result, registered ahead of write back
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      case (op_e'(ins_q.opcode))
        OP_ADD:  res_q <= ra_q + rb_q;
        OP_SUB:  res_q <= ra_q - rb_q;
        OP_MUL:  res_q <= DATA_WIDTH'(ra_q * rb_q);
        OP_IMM:  res_q <= bimm;
        OP_EQ:   res_q <= (ra_q == rb_q) ? DATA_WIDTH'(1) : ones;
        OP_LT:   res_q <= lt_ab ? DATA_WIDTH'(1) : ones;
        OP_LE:   res_q <= !lt_ba ? DATA_WIDTH'(1) : ones;
        OP_GT:   res_q <= lt_ba ? DATA_WIDTH'(1) : ones;
        OP_GE:   res_q <= !lt_ab ? DATA_WIDTH'(1) : ones;
        default: res_q <= '0;
      endcase
    end
  end

  toce_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ra_q),
    .divisor_i  (rb_q),
    .ctl_o      (dctl),
    .quot_o     (quot)
  );

  // register file write back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= '0;
    end else if (state_q == S_WB) begin
      case (op_e'(ins_q.opcode))
        OP_ADD, OP_SUB, OP_MUL, OP_IMM, OP_EQ, OP_LT, OP_LE, OP_GT, OP_GE:
          regs_q[ia] <= res_q;
        OP_DIV:  regs_q[ia] <= quot;
        OP_LOAD: regs_q[ia] <= mrd_q;
        default: ;
      endcase
    end
  end

  // return stack
  always_ff @(posedge clk_i) begin
    if (state_q == S_WB && ins_q.opcode == OP_CALL && depth_q < DW'(STACK_DEPTH))
      stk[SW'(depth_q)] <= ins_q.field_b[9:0];
  end

  // pc, depth and result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [9:0] tgt;
    logic [1:0] flt;
    if (!rst_ni) begin
      depth_q  <= '0;
      pc_q     <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      if (state_q == S_WB) begin
        tgt = pc_q;
        flt = FAULT_NONE;
        case (op_e'(ins_q.opcode))
          OP_JMP:  tgt = ins_q.field_a;
          OP_JMPC: if (rb_q == ones) tgt = ins_q.field_a;
          OP_CALL: begin
            if (depth_q >= DW'(STACK_DEPTH)) flt = FAULT_FULL;
            else begin
              tgt     = 10'(MW'(mrd_q));
              depth_q <= depth_q + 1'b1;
            end
          end
          OP_RET: begin
            if (depth_q == '0) flt = FAULT_EMPTY;
            else begin
              tgt     = srd_q;
              depth_q <= depth_q - 1'b1;
            end
          end
          default: ;
        endcase
        tgt = 10'(MW'(tgt + 1'b1));
        pc_q                  <= tgt;
        ovalid_q              <= 1'b1;
        out_q.next_pc         <= tgt;
        out_q.stack_fault     <= flt;
        out_q.print_valid     <= (ins_q.opcode == OP_PRINT);
        out_q.print_reg_value <= (ins_q.opcode == OP_PRINT) ?
                                 32'(signed'(ra_q)) : '0;
        out_q.print_mem_value <= (ins_q.opcode == OP_PRINT) ?
                                 32'(signed'(mrd_q)) : '0;
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;
endmodule

// ===== design/toce_checker.sv =====
// ----------------------------------------------------------------------------
// toce_checker: port-level checks for the execute block
// Watches the handshakes and result fields over time.
// ----------------------------------------------------------------------------
module toce_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input toce_pkg::out_word_t out_data_o
);
  import toce_pkg::*;

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // an accepted word cannot produce a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result too early");

  // no new word while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("accepted with result pending");

  // print values are zero when not a print
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.print_valid |->
      out_data_o.print_reg_value == 0 && out_data_o.print_mem_value == 0)
    else $error("print value without print");

  // fault code in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.stack_fault != 2'd3)
    else $error("bad fault code");
endmodule

bind two_operand_register_cpu_execute toce_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
